// ===== src/http_request_line_parser_assert.svh =====
// Assertion macros shared by the parser RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef HTTP_REQUEST_LINE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Invariant checked at every clock edge outside reset.
`define HRLP_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Implication from one cycle to the next.
`define HRLP_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`else

`define HRLP_ASSERT_ALWAYS(name, cond, msg)
`define HRLP_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

// ===== src/hrlp_pkg.sv =====
package hrlp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  uri_byte;
        logic [2:0]  status;
        logic        method;
        logic [11:0] hdr_end;
        logic [11:0] header_start;
        logic [8:0]  uri_len;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_METHOD  = 2'd0,
        PH_URI     = 2'd1,
        PH_LINE    = 2'd2,
        PH_HEADERS = 2'd3
    } phase_t;

    localparam logic KIND_URI    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic MTH_GET  = 1'b0;
    localparam logic MTH_POST = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_END    = 3'd1;
    localparam logic [2:0] ST_NO_SPACE1 = 3'd2;
    localparam logic [2:0] ST_BAD_METH  = 3'd3;
    localparam logic [2:0] ST_NO_SPACE2 = 3'd4;
    localparam logic [2:0] ST_URI_LONG  = 3'd5;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [23:0] TXT_GET     = 24'h474554;
    localparam logic [23:0] TXT_GET_LC  = 24'h676574;
    localparam logic [31:0] TXT_POST    = 32'h504f5354;
    localparam logic [31:0] TXT_POST_LC = 32'h706f7374;

    // Progress through the CR LF CR LF terminator.
    localparam logic [1:0] TM_NONE   = 2'd0;
    localparam logic [1:0] TM_CR     = 2'd1;
    localparam logic [1:0] TM_CRLF   = 2'd2;
    localparam logic [1:0] TM_CRLFCR = 2'd3;

endpackage

// ===== src/http_request_line_parser.sv =====
// Channel  Ports               Payload      Direction
// -------  ------------------  -----------  ---------
// input    s_valid, s_ready    s_data       in   (one request byte)
// result   m_valid, m_ready    m_data       out  (URI byte or final report)
//
// One byte is taken per cycle while s_ready is high; its result, if any, is registered.
// An output register backed by a one-entry skid register keeps s_ready high
// while a result waits, so input stalls only when both are full.
// Reset (aresetn low at a clock edge) returns the parser to the method phase
// and empties both output registers.
module http_request_line_parser #(
    parameter int MAX_LEN = 4096,
    parameter int URI_MAX = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hrlp_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output hrlp_pkg::out_item_t m_data
);
    import hrlp_pkg::*;

    localparam int PW = $clog2(MAX_LEN) + 1;
    localparam int UW = $clog2(URI_MAX + 2);

    phase_t         phase_reg, phase_next;
    logic [31:0]    method_text_reg, method_text_next;
    logic [2:0]     method_count_reg, method_count_next;
    logic [1:0]     crlf_reg, crlf_next;
    logic [PW-1:0]  position_reg, position_next;
    logic [UW-1:0]  uri_count_reg, uri_count_next;
    logic [PW-1:0]  line_offset_reg, line_offset_next;
    logic           finished_reg, finished_next;

    out_item_t      out_reg, out_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      skid_reg, skid_next;
    logic           skid_valid_reg, skid_valid_next;

    logic           accept;
    logic           pop;
    logic           res_valid;
    out_item_t      res;
    logic [UW-1:0]  emitted_len;
    logic [31:0]    emitted_wide;
    logic [31:0]    hlen_wide;
    logic [31:0]    hstart_wide;
    logic           meth_get;
    logic           meth_post;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign emitted_len  = (uri_count_reg < UW'(URI_MAX)) ? uri_count_reg : UW'(URI_MAX);
    assign emitted_wide = 32'(emitted_len);
    assign hlen_wide    = 32'(position_reg - PW'(3));
    assign hstart_wide  = 32'(line_offset_reg);

    assign meth_get  = (method_count_reg == 3'd3) &&
                       ((method_text_reg[23:0] == TXT_GET) ||
                        (method_text_reg[23:0] == TXT_GET_LC));
    assign meth_post = (method_count_reg == 3'd4) &&
                       ((method_text_reg == TXT_POST) || (method_text_reg == TXT_POST_LC));

    // Per-byte parse step.
    always_comb begin
        logic          found;
        logic          do_finish;
        logic          do_clear;
        logic [PW-1:0] pos_inc;
        logic [2:0]    st;
        out_item_t     fail_rpt;
        logic [UW-1:0] ulen_after;

        phase_next        = phase_reg;
        method_text_next  = method_text_reg;
        method_count_next = method_count_reg;
        crlf_next         = crlf_reg;
        position_next     = position_reg;
        uri_count_next    = uri_count_reg;
        line_offset_next  = line_offset_reg;
        finished_next     = finished_reg;
        res_valid         = 1'b0;
        res               = '0;
        found             = 1'b0;
        do_finish         = 1'b0;
        do_clear          = 1'b0;
        pos_inc           = position_reg + PW'(1);
        st                = ST_OK;
        ulen_after        = emitted_len;

        fail_rpt         = '0;
        fail_rpt.kind    = KIND_REPORT;
        fail_rpt.status  = ST_NO_END;
        fail_rpt.uri_len = emitted_wide[8:0];

        if (accept) begin
            if (finished_reg) begin
                do_clear = s_data.last;
            end else if (s_data.data_byte == CH_NUL) begin
                res       = fail_rpt;
                res_valid = 1'b1;
                do_finish = 1'b1;
            end else begin
                if (s_data.data_byte == CH_CR) begin
                    crlf_next = (crlf_reg == TM_CRLF) ? TM_CRLFCR : TM_CR;
                end else if (s_data.data_byte == CH_LF) begin
                    found     = (crlf_reg == TM_CRLFCR);
                    crlf_next = (crlf_reg == TM_CR) ? TM_CRLF : TM_NONE;
                end else begin
                    crlf_next = TM_NONE;
                end

                if (found) begin
                    // The first failing check in this order decides the status.
                    priority if (phase_reg == PH_METHOD) begin
                        st = ST_NO_SPACE1;
                    end else if (!meth_get && !meth_post) begin
                        st = ST_BAD_METH;
                    end else if (phase_reg == PH_URI) begin
                        st = ST_NO_SPACE2;
                    end else if (uri_count_reg > UW'(URI_MAX)) begin
                        st = ST_URI_LONG;
                    end else begin
                        st = ST_OK;
                    end
                    res.kind    = KIND_REPORT;
                    res.status  = st;
                    res.hdr_end = hlen_wide[11:0];
                    res.uri_len = emitted_wide[8:0];
                    if (st == ST_OK) begin
                        res.method = meth_post ? MTH_POST : MTH_GET;
                        // A request line ended only by the terminator's LF has no
                        // following header line.
                        if (phase_reg == PH_HEADERS &&
                            line_offset_reg != position_reg - PW'(1)) begin
                            res.header_start = hstart_wide[11:0];
                        end
                    end
                    res_valid = 1'b1;
                    do_finish = 1'b1;
                end else begin
                    unique case (phase_reg)
                        PH_METHOD: begin
                            if (s_data.data_byte == CH_SP) begin
                                phase_next = PH_URI;
                            end else begin
                                method_text_next = {method_text_reg[23:0], s_data.data_byte};
                                if (method_count_reg < 3'd5) begin
                                    method_count_next = method_count_reg + 3'd1;
                                end
                            end
                        end
                        PH_URI: begin
                            if (s_data.data_byte == CH_SP) begin
                                phase_next = PH_LINE;
                            end else if (uri_count_reg <= UW'(URI_MAX)) begin
                                if (uri_count_reg < UW'(URI_MAX)) begin
                                    res.kind     = KIND_URI;
                                    res.uri_byte = s_data.data_byte;
                                    res_valid    = 1'b1;
                                end
                                uri_count_next = uri_count_reg + UW'(1);
                            end
                        end
                        PH_LINE: begin
                            if (s_data.data_byte == CH_LF) begin
                                line_offset_next = pos_inc;
                                phase_next       = PH_HEADERS;
                            end
                        end
                        PH_HEADERS: begin
                        end
                        default: begin
                        end
                    endcase

                    position_next = pos_inc;
                    if (s_data.last || pos_inc >= PW'(MAX_LEN)) begin
                        // The length in this report counts a URI byte taken in this cycle.
                        ulen_after  = (uri_count_next < UW'(URI_MAX)) ?
                                      uri_count_next : UW'(URI_MAX);
                        res         = fail_rpt;
                        res.uri_len = 9'(ulen_after);
                        res_valid   = 1'b1;
                        do_finish   = 1'b1;
                    end
                end
            end

            if (do_finish) begin
                if (s_data.last) begin
                    do_clear = 1'b1;
                end else begin
                    finished_next = 1'b1;
                end
            end

            if (do_clear) begin
                phase_next        = PH_METHOD;
                method_text_next  = '0;
                method_count_next = '0;
                crlf_next         = TM_NONE;
                position_next     = '0;
                uri_count_next    = '0;
                line_offset_next  = '0;
                finished_next     = 1'b0;
            end
        end
    end

    // Output register with a one-entry skid behind it.
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg) begin
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || pop) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_METHOD;
            method_text_reg  <= '0;
            method_count_reg <= '0;
            crlf_reg         <= TM_NONE;
            position_reg     <= '0;
            uri_count_reg    <= '0;
            line_offset_reg  <= '0;
            finished_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            method_text_reg  <= method_text_next;
            method_count_reg <= method_count_next;
            crlf_reg         <= crlf_next;
            position_reg     <= position_next;
            uri_count_reg    <= uri_count_next;
            line_offset_reg  <= line_offset_next;
            finished_reg     <= finished_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`include "http_request_line_parser_assert.svh"

    `HRLP_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg,
        "skid full while output empty")
    `HRLP_ASSERT_ALWAYS(a_uri_count_bound, uri_count_reg <= UW'(URI_MAX + 1),
        "URI count past limit")
    `HRLP_ASSERT_ALWAYS(a_uri_item_clean,
        !(m_valid && m_data.kind == KIND_URI) ||
        (m_data.status == ST_OK && m_data.uri_len == 9'd0),
        "URI item carries report fields")
    `HRLP_ASSERT_NEXT(a_nul_ends_request,
        accept && !finished_reg && s_data.data_byte == CH_NUL,
        finished_reg || position_reg == '0,
        "zero byte did not end the request")

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrlp_pkg::*;

    localparam int REQ_LEN_LIMIT = 4096;
    localparam int URI_LIMIT = 256;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_PRINTED = 200;

    typedef enum {
        RQ_GOOD,
        RQ_LONG_URI,
        RQ_BAD_METHOD,
        RQ_NO_SPACE1,
        RQ_NO_SPACE2,
        RQ_ZERO,
        RQ_TRUNC,
        RQ_NOISE,
        RQ_LONG_LINE,
        RQ_OVERFLOW
    } msg_shape_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    in_item_t  pending_q[$];
    out_item_t expected_q[$];
    logic [7:0] draft_q[$];
    out_item_t predicted;
    out_item_t next_result;

    int errors = 0;
    int queued_bytes = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int hold_asked = 0;
    int hold_given = 0;

    int gap_plan[4] = '{0, 48, 0, 10};
    int stall_plan[4] = '{0, 0, 48, 10};
    string good_methods[4] = '{"GET", "get", "POST", "post"};
    string bad_methods[8] = '{"PUT", "Get", "GETS", "POSTS", "GE", "HEAD", "pOST", "GETGET"};
    logic [7:0] marks[4] = '{CH_CR, CH_LF, CH_SP, CH_NUL};

    // Parser state as the predictor sees it.
    phase_t      p_phase;
    logic [31:0] p_method_text;
    int          p_method_len;
    logic [1:0]  p_term;
    int          p_pos;
    int          p_uri_count;
    int          p_line_off;
    bit          p_done;

    http_request_line_parser #(
        .MAX_LEN(REQ_LEN_LIMIT),
        .URI_MAX(URI_LIMIT)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_parser();
        p_phase = PH_METHOD;
        p_method_text = '0;
        p_method_len = 0;
        p_term = TM_NONE;
        p_pos = 0;
        p_uri_count = 0;
        p_line_off = 0;
        p_done = 1'b0;
    endfunction

    function automatic int uri_emitted();
        return (p_uri_count < URI_LIMIT) ? p_uri_count : URI_LIMIT;
    endfunction

    function automatic bit method_known(output logic meth);
        meth = MTH_GET;
        if (p_method_len == 3 &&
            (p_method_text[23:0] == TXT_GET || p_method_text[23:0] == TXT_GET_LC))
            return 1'b1;
        if (p_method_len == 4 && (p_method_text == TXT_POST || p_method_text == TXT_POST_LC)) begin
            meth = MTH_POST;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic out_item_t make_report(logic [2:0] st, logic meth, int hlen, int hstart);
        out_item_t r;
        r = '0;
        r.kind = KIND_REPORT;
        r.status = st;
        r.method = meth;
        r.hdr_end = 12'(hlen);
        r.header_start = 12'(hstart);
        r.uri_len = 9'(uri_emitted());
        return r;
    endfunction

    // A report either resets the parser at once or leaves it ignoring bytes until last.
    function automatic void end_message(bit last);
        if (last)
            clear_parser();
        else
            p_done = 1'b1;
    endfunction

    function automatic bit parse_byte(input in_item_t req, output out_item_t res);
        logic [7:0] b;
        int pos;
        bit hit;
        bit emit;
        bit known;
        logic meth;
        logic [2:0] st;
        int hstart;
        b = req.data_byte;
        pos = p_pos;
        hit = 1'b0;
        emit = 1'b0;
        res = '0;
        if (p_done) begin
            if (req.last)
                clear_parser();
            return 1'b0;
        end
        if (b == CH_NUL) begin
            res = make_report(ST_NO_END, MTH_GET, 0, 0);
            end_message(req.last);
            return 1'b1;
        end
        if (b == CH_CR) begin
            p_term = (p_term == TM_CRLF) ? TM_CRLFCR : TM_CR;
        end else if (b == CH_LF) begin
            hit = (p_term == TM_CRLFCR);
            p_term = (p_term == TM_CR) ? TM_CRLF : TM_NONE;
        end else begin
            p_term = TM_NONE;
        end
        if (hit) begin
            known = method_known(meth);
            if (p_phase == PH_METHOD)
                st = ST_NO_SPACE1;
            else if (!known)
                st = ST_BAD_METH;
            else if (p_phase == PH_URI)
                st = ST_NO_SPACE2;
            else if (p_uri_count > URI_LIMIT)
                st = ST_URI_LONG;
            else
                st = ST_OK;
            hstart = 0;
            if (st != ST_OK)
                meth = MTH_GET;
            else if (p_phase == PH_HEADERS && p_line_off != pos - 1)
                hstart = p_line_off;
            res = make_report(st, meth, pos - 3, hstart);
            end_message(req.last);
            return 1'b1;
        end
        case (p_phase)
            PH_METHOD: begin
                if (b == CH_SP) begin
                    p_phase = PH_URI;
                end else begin
                    p_method_text = {p_method_text[23:0], b};
                    if (p_method_len < 5)
                        p_method_len++;
                end
            end
            PH_URI: begin
                if (b == CH_SP) begin
                    p_phase = PH_LINE;
                end else if (p_uri_count <= URI_LIMIT) begin
                    if (p_uri_count < URI_LIMIT) begin
                        res.kind = KIND_URI;
                        res.uri_byte = b;
                        emit = 1'b1;
                    end
                    p_uri_count++;
                end
            end
            PH_LINE: begin
                if (b == CH_LF) begin
                    p_line_off = pos + 1;
                    p_phase = PH_HEADERS;
                end
            end
            default: ;
        endcase
        p_pos = pos + 1;
        // A truncated buffer or the length limit overrides any URI byte of this step.
        if (req.last || p_pos >= REQ_LEN_LIMIT) begin
            res = make_report(ST_NO_END, MTH_GET, 0, 0);
            end_message(req.last);
            return 1'b1;
        end
        return emit;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Predict the result of each request byte as it is accepted, then offer the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && parse_byte(s_data, predicted))
                expected_q.push_back(predicted);
            if (pending_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_given != hold_asked) begin
            hold_given <= hold_asked;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && hold_left == 0 && $urandom_range(99) >= stall_pct;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_PRINTED)
                    $display("%0t ns: unexpected result %h, expected none", $time, m_data);
            end else begin
                next_result = expected_q.pop_front();
                check_field("kind", next_result.kind, m_data.kind);
                check_field("uri_byte", next_result.uri_byte, m_data.uri_byte);
                check_field("status", next_result.status, m_data.status);
                check_field("method", next_result.method, m_data.method);
                check_field("hdr_end", next_result.hdr_end, m_data.hdr_end);
                check_field("header_start", next_result.header_start, m_data.header_start);
                check_field("uri_len", next_result.uri_len, m_data.uri_len);
            end
        end
    end

    task automatic add_byte(input logic [7:0] b);
        draft_q.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            draft_q.push_back(s[i]);
    endtask

    task automatic add_crlf();
        draft_q.push_back(CH_CR);
        draft_q.push_back(CH_LF);
    endtask

    // Bytes that never end a field: printable text, with some high bytes mixed in.
    task automatic add_token(input int n);
        repeat (n) begin
            if ($urandom_range(7) == 0)
                draft_q.push_back(8'($urandom_range(128, 255)));
            else
                draft_q.push_back(8'($urandom_range(33, 126)));
        end
    endtask

    task automatic flush_draft();
        in_item_t it;
        for (int i = 0; i < draft_q.size(); i++) begin
            it.data_byte = draft_q[i];
            it.last = (i == draft_q.size() - 1);
            pending_q.push_back(it);
        end
        queued_bytes += draft_q.size();
        draft_q.delete();
    endtask

    task automatic send_message(input msg_shape_t shape);
        int n;
        if (shape == RQ_NOISE) begin
            n = $urandom_range(1, 24);
            repeat (n) begin
                if ($urandom_range(3) == 0)
                    add_byte(marks[$urandom_range(3)]);
                else
                    add_byte(8'($urandom));
            end
            flush_draft();
            return;
        end
        if (shape == RQ_LONG_LINE || shape == RQ_OVERFLOW) begin
            // A very long request line, either ending well before the length limit or not at all.
            add_text("GET /p ");
            add_token(shape == RQ_LONG_LINE ? 4000 : 4200);
            if (shape == RQ_LONG_LINE) begin
                add_crlf();
                add_text("H: v");
                add_crlf();
                add_crlf();
            end
            flush_draft();
            return;
        end
        if (shape == RQ_BAD_METHOD) begin
            if ($urandom_range(1))
                add_text(bad_methods[$urandom_range(7)]);
            else
                add_token($urandom_range(1, 6));
        end else begin
            add_text(good_methods[$urandom_range(3)]);
        end
        if (shape != RQ_NO_SPACE1)
            add_byte(CH_SP);
        add_token(shape == RQ_LONG_URI ? $urandom_range(250, 262) : $urandom_range(0, 20));
        if (shape != RQ_NO_SPACE1 && shape != RQ_NO_SPACE2) begin
            add_byte(CH_SP);
            add_text("HTTP/1.1");
            add_crlf();
            repeat ($urandom_range(0, 2)) begin
                add_text("X-");
                add_token($urandom_range(1, 6));
                add_text(": ");
                add_token($urandom_range(0, 10));
                add_crlf();
            end
        end else begin
            add_crlf();
        end
        add_crlf();
        if (shape == RQ_TRUNC) begin
            n = $urandom_range(1, draft_q.size() - 1);
            while (draft_q.size() > n)
                void'(draft_q.pop_back());
        end else begin
            repeat ($urandom_range(0, 4))
                add_byte(8'($urandom));
        end
        if (shape == RQ_ZERO)
            draft_q[$urandom_range(0, draft_q.size() - 1)] = CH_NUL;
        flush_draft();
    endtask

    function automatic msg_shape_t pick_shape();
        int r;
        r = $urandom_range(99);
        if (r < 62)
            return RQ_GOOD;
        if (r < 66)
            return RQ_LONG_URI;
        if (r < 72)
            return RQ_BAD_METHOD;
        if (r < 78)
            return RQ_NO_SPACE2;
        if (r < 83)
            return RQ_NO_SPACE1;
        if (r < 89)
            return RQ_ZERO;
        if (r < 95)
            return RQ_TRUNC;
        return RQ_NOISE;
    endfunction

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || expected_q.size() != 0);
    endtask

    initial begin
        int phase_start;
        clear_parser();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero byte with last, and a buffer cut short after one byte.
        add_byte(CH_NUL);
        flush_draft();
        add_text("a");
        flush_draft();
        // No space at all, then no second space so the terminator reaches the URI, then an unknown method.
        add_text("GET");
        add_crlf();
        add_crlf();
        flush_draft();
        add_text("post /");
        add_crlf();
        add_crlf();
        flush_draft();
        add_text("PUT / ");
        add_crlf();
        add_crlf();
        flush_draft();
        // Good message with a header line and a body that must be ignored.
        add_text("get /a b");
        add_crlf();
        add_text("H");
        add_crlf();
        add_crlf();
        add_byte(CH_NUL);
        add_byte(8'hff);
        flush_draft();
        // Zero byte without last, then a byte that is ignored until last.
        add_text("GE");
        add_byte(CH_NUL);
        add_text("z");
        flush_draft();
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            gap_pct = gap_plan[ph];
            stall_pct = stall_plan[ph];
            phase_start = queued_bytes;
            while (queued_bytes - phase_start < 225)
                send_message(pick_shape());
            // The receiver holds off for a long time while the sender keeps offering.
            if (ph == 0)
                hold_asked++;
            wait_drained();
        end

        gap_pct = 0;
        stall_pct = 0;
        repeat (20) @(negedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
